>>> src/tick_job_scheduler_unit_assert.svh
// Assertion macros for the tick job scheduler.
// Included by the modules that check their own state. Uses clk and rst_n.
`ifndef TICK_JOB_SCHEDULER_UNIT_ASSERT_SVH
`define TICK_JOB_SCHEDULER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TJS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TJS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TJS_ASSERT(label, prop, msg)
`define TJS_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

>>> src/tjs_pkg.sv
// Shared constants, types and helpers of the tick job scheduler.
// No dependencies.
`timescale 1ns / 1ps
package tjs_pkg;
  localparam int MAX_JOBS = 32;
  localparam int SLOT_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int TIME_W = 24;
  localparam int QUANT_W = 16;
  localparam int JCNT_W = 6;
  localparam int OSLOT_W = 5;
  localparam int POL_W = 2;
  localparam int CIDX_W = 2;
  localparam int CDATA_W = 16;

  localparam logic [POL_W-1:0] POL_FIFO = 2'd0;
  localparam logic [POL_W-1:0] POL_RR = 2'd1;
  localparam logic [POL_W-1:0] POL_SJF = 2'd2;
  localparam logic [POL_W-1:0] POL_PSJF = 2'd3;

  localparam logic [CIDX_W-1:0] REG_POLICY = 2'd0;
  localparam logic [CIDX_W-1:0] REG_QUANTUM = 2'd1;
  localparam logic [CIDX_W-1:0] REG_JOB_COUNT = 2'd2;

  localparam logic MODE_ARRIVE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic [QUANT_W-1:0] QUANTUM_RST = 16'd500;
  localparam logic [JCNT_W-1:0] JOB_COUNT_RST = 6'd1;

  typedef struct packed {
    logic [POL_W-1:0] policy;
    logic [QUANT_W-1:0] quantum;
    logic [JCNT_W-1:0] job_count;
  } tjs_cfg_t;

  typedef struct packed {
    logic running_valid;
    logic [OSLOT_W-1:0] running_slot;
    logic switched;
    logic finished;
    logic [OSLOT_W-1:0] finished_slot;
    logic all_done;
    logic dropped;
  } tjs_res_t;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] p);
    logic [SLOT_W-1:0] r;
    if (p == SLOT_W'(MAX_JOBS - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction
endpackage

>>> src/tjs_in_if.sv
// Input channel of the tick job scheduler: arrivals and ticks.
// Depends on tjs_pkg.
`timescale 1ns / 1ps
interface tjs_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic [tjs_pkg::TIME_W-1:0] exec_time;
  modport source (output valid, output mode, output exec_time, input ready);
  modport sink (input valid, input mode, input exec_time, output ready);
endinterface

>>> src/tjs_out_if.sv
// Result channel of the tick job scheduler, one transaction per tick.
// Depends on tjs_pkg.
`timescale 1ns / 1ps
interface tjs_out_if;
  logic valid;
  logic ready;
  logic running_valid;
  logic [tjs_pkg::OSLOT_W-1:0] running_slot;
  logic switched;
  logic finished;
  logic [tjs_pkg::OSLOT_W-1:0] finished_slot;
  logic all_done;
  logic dropped;
  modport source (output valid, output running_valid, output running_slot, output switched,
                  output finished, output finished_slot, output all_done, output dropped,
                  input ready);
  modport sink (input valid, input running_valid, input running_slot, input switched,
                input finished, input finished_slot, input all_done, input dropped,
                output ready);
endinterface

>>> src/tjs_cfg_if.sv
// Configuration write channel of the tick job scheduler.
// Depends on tjs_pkg.
`timescale 1ns / 1ps
interface tjs_cfg_if;
  logic valid;
  logic ready;
  logic [tjs_pkg::CIDX_W-1:0] index;
  logic [tjs_pkg::CDATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/tjs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module tjs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/tjs_core.sv
// Scheduler sequencer: job table and ready ring in RAM, read-modify-write per tick.
// Depends on tjs_pkg, tjs_ram and the assertion header.
`timescale 1ns / 1ps
`include "tick_job_scheduler_unit_assert.svh"
module tjs_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tjs_pkg::tjs_cfg_t             cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [tjs_pkg::TIME_W-1:0]    in_exec_time,
  output logic                          res_valid,
  input  logic                          res_take,
  output tjs_pkg::tjs_res_t             res
);
  import tjs_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SCAN      = 4'd1;
  localparam logic [3:0] S_RR_HEAD   = 4'd2;
  localparam logic [3:0] S_RR_SLOT   = 4'd3;
  localparam logic [3:0] S_RR_LIVE   = 4'd4;
  localparam logic [3:0] S_RR_DECIDE = 4'd5;
  localparam logic [3:0] S_RR_NEWHD  = 4'd6;
  localparam logic [3:0] S_RR_NEWDAT = 4'd7;
  localparam logic [3:0] S_COMMIT    = 4'd8;
  localparam logic [3:0] S_EXEC_RD   = 4'd9;
  localparam logic [3:0] S_EXEC_WB   = 4'd10;
  localparam logic [3:0] S_OUT       = 4'd11;

  logic [3:0] st_r, st_nxt;
  logic [CNT_W-1:0] arrived_r, arrived_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0] size_r, size_nxt;
  logic run_r, run_nxt;
  logic [SLOT_W-1:0] rslot_r, rslot_nxt;
  logic [QUANT_W-1:0] since_r, since_nxt;
  logic [JCNT_W-1:0] fcnt_r, fcnt_nxt;
  logic drop_r, drop_nxt;
  logic [CNT_W-1:0] scan_i_r, scan_i_nxt;
  logic rd_v_r, rd_v_nxt;
  logic [SLOT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic sfound_r, sfound_nxt;
  logic [SLOT_W-1:0] best_r, best_nxt;
  logic [TIME_W-1:0] bestv_r, bestv_nxt;
  logic [SLOT_W-1:0] hslot_r, hslot_nxt;
  logic [SLOT_W-1:0] pick_r, pick_nxt;
  logic found_r, found_nxt;
  logic sw_r, sw_nxt;
  logic fin_r, fin_nxt;
  logic valid_r, valid_nxt;

  logic rt_we;
  logic [SLOT_W-1:0] rt_waddr, rt_raddr;
  logic [TIME_W-1:0] rt_wdata, rt_rdata;
  logic ring_we;
  logic [SLOT_W-1:0] ring_waddr, ring_raddr, ring_wdata, ring_rdata;

  logic [QUANT_W-1:0] q_eff;
  logic [TIME_W-1:0] nv;
  logic shortest;

  tjs_ram #(.WIDTH(TIME_W), .DEPTH(MAX_JOBS)) u_rt_ram (
    .clk(clk), .we(rt_we), .waddr(rt_waddr), .wdata(rt_wdata),
    .raddr(rt_raddr), .rdata(rt_rdata)
  );

  tjs_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_JOBS)) u_ring_ram (
    .clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
    .raddr(ring_raddr), .rdata(ring_rdata)
  );

  assign q_eff = (cfg.quantum == '0) ? QUANT_W'(1) : cfg.quantum;
  assign nv = (rt_rdata != '0) ? rt_rdata - 1'b1 : rt_rdata;
  assign shortest = (cfg.policy != POL_FIFO);
  assign in_ready = (st_r == S_IDLE);
  assign res_valid = (st_r == S_OUT);

  always_comb begin
    res.running_valid = valid_r;
    res.running_slot = valid_r ? OSLOT_W'(rslot_r) : '0;
    res.switched = sw_r;
    res.finished = fin_r;
    res.finished_slot = fin_r ? OSLOT_W'(rslot_r) : '0;
    res.all_done = (fcnt_r >= cfg.job_count);
    res.dropped = drop_r;
  end

  always_comb begin
    st_nxt = st_r;
    arrived_nxt = arrived_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    size_nxt = size_r;
    run_nxt = run_r;
    rslot_nxt = rslot_r;
    since_nxt = since_r;
    fcnt_nxt = fcnt_r;
    drop_nxt = drop_r;
    scan_i_nxt = scan_i_r;
    rd_v_nxt = 1'b0;
    rd_idx_nxt = rd_idx_r;
    sfound_nxt = sfound_r;
    best_nxt = best_r;
    bestv_nxt = bestv_r;
    hslot_nxt = hslot_r;
    pick_nxt = pick_r;
    found_nxt = found_r;
    sw_nxt = sw_r;
    fin_nxt = fin_r;
    valid_nxt = valid_r;
    rt_we = 1'b0;
    rt_waddr = SLOT_W'(arrived_r);
    rt_wdata = (in_exec_time == '0) ? TIME_W'(1) : in_exec_time;
    rt_raddr = rslot_r;
    ring_we = 1'b0;
    ring_waddr = tail_r;
    ring_wdata = SLOT_W'(arrived_r);
    ring_raddr = head_r;

    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_ARRIVE) begin
            if (arrived_r == CNT_W'(MAX_JOBS)) begin
              drop_nxt = 1'b1;
            end else begin
              rt_we = 1'b1;
              ring_we = 1'b1;
              tail_nxt = slot_inc(tail_r);
              size_nxt = size_r + 1'b1;
              arrived_nxt = arrived_r + 1'b1;
            end
          end else begin
            sw_nxt = 1'b0;
            fin_nxt = 1'b0;
            if ((cfg.policy == POL_FIFO || cfg.policy == POL_SJF) && run_r) begin
              pick_nxt = rslot_r;
              found_nxt = 1'b1;
              st_nxt = S_COMMIT;
            end else if (cfg.policy == POL_RR) begin
              st_nxt = S_RR_HEAD;
            end else begin
              scan_i_nxt = '0;
              sfound_nxt = 1'b0;
              best_nxt = '0;
              st_nxt = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        rt_raddr = SLOT_W'(scan_i_r);
        if (scan_i_r < arrived_r) begin
          rd_v_nxt = 1'b1;
          rd_idx_nxt = SLOT_W'(scan_i_r);
          scan_i_nxt = scan_i_r + 1'b1;
        end else if (!rd_v_r) begin
          found_nxt = sfound_r;
          pick_nxt = best_r;
          st_nxt = S_COMMIT;
        end
        if (rd_v_r && rt_rdata != '0 && (!sfound_r || (shortest && rt_rdata < bestv_r))) begin
          sfound_nxt = 1'b1;
          best_nxt = rd_idx_r;
          bestv_nxt = rt_rdata;
        end
      end
      S_RR_HEAD: begin
        st_nxt = (size_r == '0) ? S_RR_DECIDE : S_RR_SLOT;
      end
      S_RR_SLOT: begin
        hslot_nxt = ring_rdata;
        rt_raddr = ring_rdata;
        st_nxt = S_RR_LIVE;
      end
      S_RR_LIVE: begin
        if (rt_rdata == '0) begin
          head_nxt = slot_inc(head_r);
          size_nxt = size_r - 1'b1;
          st_nxt = S_RR_HEAD;
        end else begin
          st_nxt = S_RR_DECIDE;
        end
      end
      S_RR_DECIDE: begin
        found_nxt = 1'b1;
        pick_nxt = rslot_r;
        st_nxt = S_COMMIT;
        if (!run_r) begin
          found_nxt = (size_r != '0);
          pick_nxt = hslot_r;
        end else if (since_r >= q_eff) begin
          since_nxt = '0;
          if (size_r != '0) begin
            ring_we = 1'b1;
            ring_wdata = hslot_r;
            head_nxt = slot_inc(head_r);
            tail_nxt = slot_inc(tail_r);
            st_nxt = S_RR_NEWHD;
          end
        end
      end
      S_RR_NEWHD: begin
        st_nxt = S_RR_NEWDAT;
      end
      S_RR_NEWDAT: begin
        pick_nxt = ring_rdata;
        found_nxt = 1'b1;
        st_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (found_r && (!run_r || pick_r != rslot_r)) begin
          sw_nxt = 1'b1;
          run_nxt = 1'b1;
          rslot_nxt = pick_r;
          since_nxt = '0;
        end
        if (found_r || run_r) begin
          st_nxt = S_EXEC_RD;
        end else begin
          valid_nxt = 1'b0;
          st_nxt = S_OUT;
        end
      end
      S_EXEC_RD: begin
        st_nxt = S_EXEC_WB;
      end
      S_EXEC_WB: begin
        valid_nxt = 1'b1;
        rt_we = 1'b1;
        rt_waddr = rslot_r;
        rt_wdata = nv;
        if (since_r != '1) begin
          since_nxt = since_r + 1'b1;
        end
        if (nv == '0) begin
          fin_nxt = 1'b1;
          run_nxt = 1'b0;
          if (fcnt_r != '1) begin
            fcnt_nxt = fcnt_r + 1'b1;
          end
          if (size_r != '0 && ring_rdata == rslot_r) begin
            head_nxt = slot_inc(head_r);
            size_nxt = size_r - 1'b1;
          end
        end
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (res_take) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      arrived_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      size_r <= '0;
      run_r <= 1'b0;
      rslot_r <= '0;
      since_r <= '0;
      fcnt_r <= '0;
      drop_r <= 1'b0;
      rd_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      arrived_r <= arrived_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      size_r <= size_nxt;
      run_r <= run_nxt;
      rslot_r <= rslot_nxt;
      since_r <= since_nxt;
      fcnt_r <= fcnt_nxt;
      drop_r <= drop_nxt;
      rd_v_r <= rd_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_i_r <= scan_i_nxt;
    rd_idx_r <= rd_idx_nxt;
    sfound_r <= sfound_nxt;
    best_r <= best_nxt;
    bestv_r <= bestv_nxt;
    hslot_r <= hslot_nxt;
    pick_r <= pick_nxt;
    found_r <= found_nxt;
    sw_r <= sw_nxt;
    fin_r <= fin_nxt;
    valid_r <= valid_nxt;
  end

  `TJS_ASSERT(a_ring_le_arrived, size_r <= arrived_r, "ring holds more jobs than arrived")
  `TJS_ASSERT(a_arrived_cap, arrived_r <= CNT_W'(MAX_JOBS), "arrival count past capacity")
  `TJS_ASSERT(a_drop_sticky, !$fell(drop_r), "drop flag cleared outside reset")
  `TJS_ASSERT(a_finish_stops, (st_r == S_EXEC_WB && nv == '0) |=> !run_r,
              "finished job still marked running")
endmodule

>>> src/tick_job_scheduler_unit.sv
// Tick job scheduler top level: configuration registers, result register, sequencer.
// Depends on tjs_pkg, the channel interfaces and tjs_core.
// An arrival is written to the job table and ring, or sets the drop flag when full. A
// tick of FIFO or SJF with a job already running goes straight to commit; a tick that
// must pick a job (FIFO or SJF when idle, PSJF always) scans the job table one slot
// per cycle through the table RAM read port. Round-robin ticks read the ring head and
// pop each dead ring head (left by a policy change) before deciding. A finished tick
// result sits in the output register while new transactions are accepted.
`timescale 1ns / 1ps
module tick_job_scheduler_unit (
  input logic        clk,
  input logic        rst_n,
  tjs_in_if.sink     in_ch,
  tjs_out_if.source  out_ch,
  tjs_cfg_if.sink    cfg_ch
);
  import tjs_pkg::*;

  tjs_cfg_t cfg_r;
  logic out_valid_r;
  tjs_res_t out_r;
  tjs_res_t res;
  logic res_valid, res_take;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.policy <= POL_FIFO;
      cfg_r.quantum <= QUANTUM_RST;
      cfg_r.job_count <= JOB_COUNT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_POLICY: cfg_r.policy <= cfg_ch.data[POL_W-1:0];
        REG_QUANTUM: cfg_r.quantum <= cfg_ch.data[QUANT_W-1:0];
        REG_JOB_COUNT: cfg_r.job_count <= cfg_ch.data[JCNT_W-1:0];
        default: ;
      endcase
    end
  end

  tjs_core u_core (
    .clk(clk),
    .rst_n(rst_n),
    .cfg(cfg_r),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .in_mode(in_ch.mode),
    .in_exec_time(in_ch.exec_time),
    .res_valid(res_valid),
    .res_take(res_take),
    .res(res)
  );

  assign res_take = res_valid && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.running_valid = out_r.running_valid;
  assign out_ch.running_slot = out_r.running_slot;
  assign out_ch.switched = out_r.switched;
  assign out_ch.finished = out_r.finished;
  assign out_ch.finished_slot = out_r.finished_slot;
  assign out_ch.all_done = out_r.all_done;
  assign out_ch.dropped = out_r.dropped;
endmodule
